/* design/plwc_pkg.sv */
// shared widths, constants and word types of the polyline length-weighted centroid core
package plwc_pkg;

    // coordinate and difference widths
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;

    // serial steps done in each cycle by every iterative unit
    localparam int STEPS_PER_CYCLE = 2;

    // shift-add multiplier lanes: 16-bit multiplicand, multiplier padded to 18 bits
    localparam int MAG_W   = COORD_W;
    localparam int MULB_W  = 18;
    localparam int PROD_W  = MAG_W + MULB_W;
    localparam int WPROD_W = PROD_W + 1;

    // square root: radicand padded to an even number of root digits
    localparam int LEN_W  = 17;
    localparam int ROOT_W = 18;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    // accumulators and divider
    localparam int ACC_W = 64;
    localparam int TOT_W = 32;
    localparam int QUO_W = COORD_W + 1;

    // cycle counts of the serial units
    localparam int MUL_CYCLES  = MULB_W / STEPS_PER_CYCLE;
    localparam int ROOT_CYCLES = ROOT_W / STEPS_PER_CYCLE;
    localparam int DIV_CYCLES  = ACC_W / STEPS_PER_CYCLE;
    localparam int EDGE_CNT_W  = $clog2((MUL_CYCLES > ROOT_CYCLES) ? MUL_CYCLES : ROOT_CYCLES);
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // saturation limits of a centroid coordinate
    localparam logic [COORD_W-1:0] CENTER_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] CENTER_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [QUO_W-1:0]   POS_LIMIT  = QUO_W'(2 ** (COORD_W - 1) - 1);
    localparam logic [QUO_W-1:0]   NEG_LIMIT  = QUO_W'(2 ** (COORD_W - 1));

    // input word: one vertex
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } plwc_in_t;

    // output word: one centroid
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
    } plwc_out_t;

    // edge unit request: endpoints a and b
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
    } plwc_edge_req_t;

    // edge unit status and result
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [LEN_W-1:0]   len;
        logic [WPROD_W-1:0] prod_x;
        logic [WPROD_W-1:0] prod_y;
    } plwc_edge_res_t;

endpackage

/* design/polyline_length_weighted_centroid_core.sv */
// top level: vertex sequencing, weighted sums, total length and centroid output
// a vertex that is not the last of its polygon runs through the serial edge unit
// (take the word, squares, sum, square root, products, accumulate); a first vertex is
// only stored; a last vertex adds the closing edge when it differs from the first,
// then the start of the two 64-by-32 dividers, the division and the output register load
// reset is synchronous, clears control state and the held centroid
module polyline_length_weighted_centroid_core import plwc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  plwc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output plwc_out_t m_data
);

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_EDGE  = 5'b00010,
        T_CLOSE = 5'b00100,
        T_FIN   = 5'b01000,
        T_DIV   = 5'b10000
    } t_state_t;

    t_state_t           state_reg, state_next;
    logic [COORD_W-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [COORD_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [ACC_W-1:0]   sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic               awaiting_reg, awaiting_next;
    logic               last_reg, last_next;
    logic [COORD_W-1:0] held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic               m_valid_reg, m_valid_next;
    plwc_out_t          m_data_reg, m_data_next;

    plwc_edge_req_t     edge_req;
    plwc_edge_res_t     edge_res;
    logic               edge_start;
    logic               div_start;
    logic               div_busy_x, div_busy_y;
    logic [COORD_W-1:0] quo_x, quo_y;
    logic [ACC_W-1:0]   acc_x, acc_y;
    logic [TOT_W:0]     tot_sum;
    logic [TOT_W-1:0]   tot_new;
    logic               closing_needed;
    logic [COORD_W-1:0] cx, cy;

    // edge request: previous to incoming vertex, or first to last for the closing edge
    always_comb begin
        if (state_reg == T_IDLE) begin
            edge_req.ax = prev_x_reg;
            edge_req.ay = prev_y_reg;
            edge_req.bx = s_data.point_x;
            edge_req.by = s_data.point_y;
        end else begin
            edge_req.ax = first_x_reg;
            edge_req.ay = first_y_reg;
            edge_req.bx = prev_x_reg;
            edge_req.by = prev_y_reg;
        end
    end

    plwc_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (edge_start),
        .req     (edge_req),
        .res     (edge_res)
    );

    plwc_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_x_reg),
        .divisor  (total_reg),
        .busy     (div_busy_x),
        .quotient (quo_x)
    );

    plwc_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_y_reg),
        .divisor  (total_reg),
        .busy     (div_busy_y),
        .quotient (quo_y)
    );

    // accumulate one edge: wrapping sums, saturating total
    always_comb begin
        acc_x   = sum_x_reg + {{(ACC_W-WPROD_W){edge_res.prod_x[WPROD_W-1]}}, edge_res.prod_x};
        acc_y   = sum_y_reg + {{(ACC_W-WPROD_W){edge_res.prod_y[WPROD_W-1]}}, edge_res.prod_y};
        tot_sum = {1'b0, total_reg} + (TOT_W+1)'(edge_res.len);
        tot_new = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
    end

    // closing edge only when the last vertex differs from the first
    assign closing_needed = (first_x_reg != prev_x_reg) || (first_y_reg != prev_y_reg);

    // centroid with zero sum or zero total keeping the held value
    always_comb begin
        cx = ((sum_x_reg == '0) || (total_reg == '0)) ? held_x_reg : quo_x;
        cy = ((sum_y_reg == '0) || (total_reg == '0)) ? held_y_reg : quo_y;
    end

    // main sequencer
    always_comb begin
        state_next    = state_reg;
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        total_next    = total_reg;
        awaiting_next = awaiting_reg;
        last_next     = last_reg;
        held_x_next   = held_x_reg;
        held_y_next   = held_y_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        edge_start    = 1'b0;
        div_start     = 1'b0;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    prev_x_next = s_data.point_x;
                    prev_y_next = s_data.point_y;
                    last_next   = s_data.last_point;
                    if (awaiting_reg) begin
                        first_x_next  = s_data.point_x;
                        first_y_next  = s_data.point_y;
                        sum_x_next    = '0;
                        sum_y_next    = '0;
                        total_next    = '0;
                        awaiting_next = 1'b0;
                        state_next    = s_data.last_point ? T_FIN : T_IDLE;
                    end else begin
                        edge_start = 1'b1;
                        state_next = T_EDGE;
                    end
                end
            end
            T_EDGE: begin
                if (edge_res.done) begin
                    sum_x_next = acc_x;
                    sum_y_next = acc_y;
                    total_next = tot_new;
                    if (!last_reg) begin
                        state_next = T_IDLE;
                    end else if (closing_needed) begin
                        edge_start = 1'b1;
                        state_next = T_CLOSE;
                    end else begin
                        state_next = T_FIN;
                    end
                end
            end
            T_CLOSE: begin
                if (edge_res.done) begin
                    sum_x_next = acc_x;
                    sum_y_next = acc_y;
                    total_next = tot_new;
                    state_next = T_FIN;
                end
            end
            T_FIN: begin
                div_start  = 1'b1;
                state_next = T_DIV;
            end
            T_DIV: begin
                if (!div_busy_x && !div_busy_y && (!m_valid_reg || m_ready)) begin
                    held_x_next          = cx;
                    held_y_next          = cy;
                    m_data_next.center_x = cx;
                    m_data_next.center_y = cy;
                    m_valid_next         = 1'b1;
                    awaiting_next        = 1'b1;
                    state_next           = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    // control registers and held centroid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            awaiting_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            awaiting_reg <= awaiting_next;
            m_valid_reg  <= m_valid_next;
            held_x_reg   <= held_x_next;
            held_y_reg   <= held_y_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        sum_x_reg   <= sum_x_next;
        sum_y_reg   <= sum_y_next;
        total_reg   <= total_next;
        last_reg    <= last_next;
        m_data_reg  <= m_data_next;
    end

    // ports
    assign s_ready = (state_reg == T_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // an edge is only started when the sequencer goes on to wait for it
    a_edge_start: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_start |=> (state_reg == T_EDGE || state_reg == T_CLOSE))
        else $error("edge started without a waiting state");

    // both dividers run after a start
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (div_busy_x && div_busy_y))
        else $error("divider not busy after start");

    // a new result appears only out of the division wait
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == T_DIV))
        else $error("result word loaded outside division wait");

    // taking a word implies the serial units are free
    a_units_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!edge_res.busy && !div_busy_x && !div_busy_y))
        else $error("input ready while a serial unit is busy");
`endif

endmodule

/* design/plwc_edge.sv */
// edge unit: serial squares, digit-by-digit square root and length-times-midpoint products
module plwc_edge import plwc_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  plwc_edge_req_t req,
    output plwc_edge_res_t res
);

    typedef enum logic [5:0] {
        E_IDLE = 6'b000001,
        E_SQ   = 6'b000010,
        E_SUM  = 6'b000100,
        E_ROOT = 6'b001000,
        E_MUL  = 6'b010000,
        E_DONE = 6'b100000
    } e_state_t;

    e_state_t              state_reg, state_next;
    logic [EDGE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0]      a_x_reg, a_x_next, a_y_reg, a_y_next;
    logic [PROD_W-1:0]     p_x_reg, p_x_next, p_y_reg, p_y_next;
    logic [MAG_W-1:0]      mid_x_reg, mid_x_next, mid_y_reg, mid_y_next;
    logic                  neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [LEN_W-1:0]      len_reg, len_next;

    logic [DIFF_W-1:0]     dx, dy, adx, ady, sx, sy, sx_adj, sy_adj;
    logic [MAG_W-1:0]      mx, my, amx, amy;
    logic [RAD_W-1:0]      rad_w;
    logic [REM_W-1:0]      rem_w, rem_sh, trial;
    logic [ROOT_W-1:0]     root_w;
    logic [WPROD_W-1:0]    px_ext, py_ext;

    // a few shift-add steps: multiplier bits leave at the bottom, product fills in
    function automatic logic [PROD_W-1:0] mul_step(input logic [PROD_W-1:0] p,
                                                    input logic [MAG_W-1:0]  a);
        logic [PROD_W-1:0] r;
        logic [MAG_W:0]    hi;
        r = p;
        for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
            hi = {1'b0, r[PROD_W-1:MULB_W]} + (r[0] ? {1'b0, a} : {(MAG_W+1){1'b0}});
            r  = {hi, r[MULB_W-1:1]};
        end
        return r;
    endfunction

    // differences and truncated midpoints of the requested edge
    always_comb begin
        dx     = {req.bx[COORD_W-1], req.bx} - {req.ax[COORD_W-1], req.ax};
        dy     = {req.by[COORD_W-1], req.by} - {req.ay[COORD_W-1], req.ay};
        adx    = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
        ady    = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
        sx     = {req.bx[COORD_W-1], req.bx} + {req.ax[COORD_W-1], req.ax};
        sy     = {req.by[COORD_W-1], req.by} + {req.ay[COORD_W-1], req.ay};
        sx_adj = sx + DIFF_W'(sx[DIFF_W-1]);
        sy_adj = sy + DIFF_W'(sy[DIFF_W-1]);
        mx     = sx_adj[DIFF_W-1:1];
        my     = sy_adj[DIFF_W-1:1];
        amx    = mx[MAG_W-1] ? (~mx + MAG_W'(1)) : mx;
        amy    = my[MAG_W-1] ? (~my + MAG_W'(1)) : my;
    end

    // square root digits for this cycle
    always_comb begin
        rad_w  = rad_reg;
        rem_w  = rem_reg;
        root_w = root_reg;
        rem_sh = '0;
        trial  = '0;
        for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
            rem_sh = {rem_w[REM_W-3:0], rad_w[RAD_W-1 -: 2]};
            rad_w  = {rad_w[RAD_W-3:0], 2'b00};
            trial  = REM_W'({root_w, 2'b01});
            if (rem_sh >= trial) begin
                rem_w  = rem_sh - trial;
                root_w = {root_w[ROOT_W-2:0], 1'b1};
            end else begin
                rem_w  = rem_sh;
                root_w = {root_w[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // sequencer: squares, sum, root, products
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_x_next   = a_x_reg;
        a_y_next   = a_y_reg;
        p_x_next   = p_x_reg;
        p_y_next   = p_y_reg;
        mid_x_next = mid_x_reg;
        mid_y_next = mid_y_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        len_next   = len_reg;
        unique case (state_reg) inside
            E_IDLE, E_DONE: begin
                state_next = E_IDLE;
                if (start) begin
                    a_x_next   = adx[MAG_W-1:0];
                    a_y_next   = ady[MAG_W-1:0];
                    p_x_next   = PROD_W'(adx[MAG_W-1:0]);
                    p_y_next   = PROD_W'(ady[MAG_W-1:0]);
                    mid_x_next = amx;
                    mid_y_next = amy;
                    neg_x_next = mx[MAG_W-1];
                    neg_y_next = my[MAG_W-1];
                    cnt_next   = '0;
                    state_next = E_SQ;
                end
            end
            E_SQ: begin
                p_x_next = mul_step(p_x_reg, a_x_reg);
                p_y_next = mul_step(p_y_reg, a_y_reg);
                cnt_next = cnt_reg + EDGE_CNT_W'(1);
                if (cnt_reg == EDGE_CNT_W'(MUL_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = E_SUM;
                end
            end
            E_SUM: begin
                rad_next   = RAD_W'(p_x_reg) + RAD_W'(p_y_reg);
                rem_next   = '0;
                root_next  = '0;
                state_next = E_ROOT;
            end
            E_ROOT: begin
                rad_next  = rad_w;
                rem_next  = rem_w;
                root_next = root_w;
                cnt_next  = cnt_reg + EDGE_CNT_W'(1);
                if (cnt_reg == EDGE_CNT_W'(ROOT_CYCLES - 1)) begin
                    cnt_next   = '0;
                    len_next   = root_w[LEN_W-1:0];
                    a_x_next   = mid_x_reg;
                    a_y_next   = mid_y_reg;
                    p_x_next   = PROD_W'(root_w);
                    p_y_next   = PROD_W'(root_w);
                    state_next = E_MUL;
                end
            end
            E_MUL: begin
                p_x_next = mul_step(p_x_reg, a_x_reg);
                p_y_next = mul_step(p_y_reg, a_y_reg);
                cnt_next = cnt_reg + EDGE_CNT_W'(1);
                if (cnt_reg == EDGE_CNT_W'(MUL_CYCLES - 1)) begin
                    cnt_next   = '0;
                    state_next = E_DONE;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        a_x_reg   <= a_x_next;
        a_y_reg   <= a_y_next;
        p_x_reg   <= p_x_next;
        p_y_reg   <= p_y_next;
        mid_x_reg <= mid_x_next;
        mid_y_reg <= mid_y_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        len_reg   <= len_next;
    end

    // signed products and status
    always_comb begin
        px_ext     = {1'b0, p_x_reg};
        py_ext     = {1'b0, p_y_reg};
        res.busy   = (state_reg != E_IDLE);
        res.done   = (state_reg == E_DONE);
        res.len    = len_reg;
        res.prod_x = neg_x_reg ? (~px_ext + WPROD_W'(1)) : px_ext;
        res.prod_y = neg_y_reg ? (~py_ext + WPROD_W'(1)) : py_ext;
    end

endmodule

/* design/plwc_div.sv */
// serial signed-by-unsigned divider with saturation to a 16-bit coordinate
module plwc_div import plwc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ACC_W-1:0]   dividend,
    input  logic [TOT_W-1:0]   divisor,
    output logic               busy,
    output logic [COORD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0]     dsr_reg, dsr_next;
    logic [TOT_W-1:0]     rem_reg, rem_next;
    logic [TOT_W-1:0]     dvs_reg, dvs_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic                 ovf_reg, ovf_next;
    logic                 neg_reg, neg_next;

    logic [ACC_W-1:0]     dsr_w;
    logic [TOT_W-1:0]     rem_w;
    logic [TOT_W:0]       rem_sh;
    logic [QUO_W-1:0]     q_w;
    logic                 ovf_w;
    logic                 over;
    logic [QUO_W-1:0]     q_neg;

    // restoring division, a few quotient bits per cycle
    always_comb begin
        dsr_w  = dsr_reg;
        rem_w  = rem_reg;
        q_w    = q_reg;
        ovf_w  = ovf_reg;
        rem_sh = '0;
        for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
            rem_sh = {rem_w, dsr_w[ACC_W-1]};
            dsr_w  = {dsr_w[ACC_W-2:0], 1'b0};
            ovf_w  = ovf_w | q_w[QUO_W-1];
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_w = TOT_W'(rem_sh - {1'b0, dvs_reg});
                q_w   = {q_w[QUO_W-2:0], 1'b1};
            end else begin
                rem_w = rem_sh[TOT_W-1:0];
                q_w   = {q_w[QUO_W-2:0], 1'b0};
            end
        end
    end

    // load on start, iterate while busy
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        if (start) begin
            neg_next  = dividend[ACC_W-1];
            dsr_next  = dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dsr_next = dsr_w;
            rem_next = rem_w;
            q_next   = q_w;
            ovf_next = ovf_w;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    // sign and saturation
    always_comb begin
        q_neg = ~q_reg + QUO_W'(1);
        if (neg_reg) begin
            over     = ovf_reg || (q_reg > NEG_LIMIT);
            quotient = over ? CENTER_MIN : q_neg[COORD_W-1:0];
        end else begin
            over     = ovf_reg || (q_reg > POS_LIMIT);
            quotient = over ? CENTER_MAX : q_reg[COORD_W-1:0];
        end
    end

    assign busy = busy_reg;

endmodule
